FILE: sv/etwc_pkg.sv
// ---------------------------------------------------------------------------
// etwc_pkg
// Shared types and constants for the edge-triggered window capture block.
// ---------------------------------------------------------------------------
package etwc_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned OFF_W    = 10;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // default ring depth
  localparam int unsigned DEPTH_DEFAULT = 1024;

  // entries of the front/back queue
  localparam int unsigned QUEUE_DEPTH = 4;

  // item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_REARM  = 2'd1,
    MODE_READ   = 2'd2
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 1'd0,
    CFG_EDGE_FALLING = 1'd1
  } cfg_reg_t;

  // classified item handed from front to back
  typedef struct packed {
    mode_t               mode;
    logic [SAMPLE_W-1:0] value;     // converted sample
    logic [OFF_W-1:0]    offset;    // read offset reduced modulo depth
  } item_t;

  // byte swap and keep bits 13..2 of the swapped word
  function automatic logic [SAMPLE_W-1:0] convert_word(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] swapped;
    swapped = {raw[7:0], raw[15:8]};
    return swapped[13:2];
  endfunction

endpackage

FILE: sv/etwc_ram.sv
// ---------------------------------------------------------------------------
// etwc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module etwc_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/etwc_front.sv
// ---------------------------------------------------------------------------
// etwc_front
// Input stage: converts the raw word, classifies the beat and reduces the
// read offset modulo the ring depth by reciprocal multiplication.
// ---------------------------------------------------------------------------
module etwc_front
  import etwc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [RAW_W-1:0] in_raw_word,
  input  logic [OFF_W-1:0] in_read_offset,
  output logic             push_valid,
  input  logic             push_ready,
  output item_t            push_item
);

  localparam int unsigned SHIFT  = 20;
  localparam int unsigned RECIP  = (1 << SHIFT) / DEPTH;
  localparam int unsigned PROD_W = OFF_W + SHIFT;

  logic              a_valid_r;
  item_t             a_item_r;
  logic [PROD_W-1:0] a_prod_r;

  logic [OFF_W-1:0]  q_est;
  logic [31:0]       q_times_d;
  logic [OFF_W-1:0]  r_est;
  logic [OFF_W-1:0]  r_mod;

  assign in_ready = !a_valid_r || push_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  // stage payload and offset-times-reciprocal product
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_item_r.mode   <= mode_t'(in_mode);
      a_item_r.value  <= convert_word(in_raw_word);
      a_item_r.offset <= in_read_offset;
      a_prod_r        <= PROD_W'(in_read_offset) * PROD_W'(RECIP);
    end
  end

  // quotient estimate is exact or one low, so one correction step
  always_comb begin
    q_est     = a_prod_r[PROD_W-1:SHIFT];
    q_times_d = 32'(q_est) * 32'(DEPTH);
    r_est     = a_item_r.offset - q_times_d[OFF_W-1:0];
    if (32'(r_est) >= 32'(DEPTH)) begin
      r_mod = r_est - OFF_W'(DEPTH);
    end else begin
      r_mod = r_est;
    end
  end

  assign push_valid       = a_valid_r;
  assign push_item.mode   = a_item_r.mode;
  assign push_item.value  = a_item_r.value;
  assign push_item.offset = r_mod;

endmodule

FILE: sv/etwc_queue.sv
// ---------------------------------------------------------------------------
// etwc_queue
// Short register queue that decouples the front stage from the back end.
// ---------------------------------------------------------------------------
module etwc_queue
  import etwc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  tail_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[head_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        tail_r <= (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      end
      if (do_pop) begin
        head_r <= (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[tail_r] <= push_item;
    end
  end

endmodule

FILE: sv/etwc_back.sv
// ---------------------------------------------------------------------------
// etwc_back
// Capture engine: trigger detection, ring writes, window reads and the
// result register.
// ---------------------------------------------------------------------------
module etwc_back
  import etwc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  item_t                 pop_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_sample_value,
  output logic [SAMPLE_W-1:0]   out_read_sample,
  output logic                  out_is_triggered,
  output logic                  out_capture_done,
  output logic [OFF_W-1:0]      out_trigger_position
);

  localparam int unsigned HALF = DEPTH / 2;
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned HW   = $clog2(HALF + 1);

  // configuration
  logic [SAMPLE_W-1:0] threshold_r;
  logic                edge_falling_r;

  // capture state
  logic [AW-1:0]       wr_pos_r,  wr_pos_nxt;
  logic [HW-1:0]       pre_cnt_r, pre_cnt_nxt;
  logic [HW-1:0]       post_cnt_r, post_cnt_nxt;
  logic                fired_r,   fired_nxt;
  logic                done_r,    done_nxt;
  logic [AW-1:0]       trig_r,    trig_nxt;
  logic [AW-1:0]       base_r,    base_nxt;
  logic [SAMPLE_W-1:0] prev_r,    prev_nxt;
  logic [FW-1:0]       fill_r,    fill_nxt;

  // result register
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_value_r;
  logic                out_hit_r,   hit_nxt;
  logic                out_fired_r;
  logic                out_done_r;
  logic [OFF_W-1:0]    out_trig_pos_r;

  logic                issue;
  logic                crossing;
  logic [AW:0]         base_sum;
  logic [AW:0]         rd_sum;
  logic [AW-1:0]       rd_idx;
  logic                ram_we;
  logic                ram_re;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [AW+OFF_W-1:0] trig_ext;

  assign pop_ready = !out_valid_r || out_ready;
  assign issue     = pop_valid && pop_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= '0;
      edge_falling_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_THRESHOLD:    threshold_r    <= cfg_wdata[SAMPLE_W-1:0];
        CFG_EDGE_FALLING: edge_falling_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // threshold crossing between previous and current sample
  always_comb begin
    if (!edge_falling_r) begin
      crossing = (prev_r <= threshold_r) && (pop_item.value > threshold_r);
    end else begin
      crossing = (prev_r >= threshold_r) && (pop_item.value < threshold_r);
    end
  end

  // oldest window position for a trigger at the current write position
  always_comb begin
    base_sum = {1'b0, wr_pos_r} + (AW+1)'(DEPTH - HALF);
    if (base_sum >= (AW+1)'(DEPTH)) begin
      base_sum = base_sum - (AW+1)'(DEPTH);
    end
  end

  // window read index
  always_comb begin
    rd_sum = {1'b0, base_r} + (AW+1)'(pop_item.offset);
    if (rd_sum >= (AW+1)'(DEPTH)) begin
      rd_sum = rd_sum - (AW+1)'(DEPTH);
    end
    rd_idx = rd_sum[AW-1:0];
  end

  // next capture state for the item at the queue head
  always_comb begin
    wr_pos_nxt   = wr_pos_r;
    pre_cnt_nxt  = pre_cnt_r;
    post_cnt_nxt = post_cnt_r;
    fired_nxt    = fired_r;
    done_nxt     = done_r;
    trig_nxt     = trig_r;
    base_nxt     = base_r;
    prev_nxt     = prev_r;
    fill_nxt     = fill_r;
    hit_nxt      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    case (pop_item.mode)
      MODE_SAMPLE: begin
        ram_we = issue && !done_r;
        if (!done_r && (32'(fill_r) < 32'(DEPTH))) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (32'(pre_cnt_r) < 32'(HALF)) begin
          pre_cnt_nxt = pre_cnt_r + 1'b1;
        end
        if (!fired_r && (32'(pre_cnt_nxt) >= 32'(HALF)) && crossing) begin
          fired_nxt    = 1'b1;
          trig_nxt     = wr_pos_r;
          base_nxt     = base_sum[AW-1:0];
          pre_cnt_nxt  = '0;
          post_cnt_nxt = '0;
        end
        if (fired_nxt && !done_r) begin
          post_cnt_nxt = post_cnt_nxt + 1'b1;
          if (32'(post_cnt_nxt) >= 32'(HALF)) begin
            done_nxt = 1'b1;
          end
        end
        wr_pos_nxt = (wr_pos_r == AW'(DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
        prev_nxt   = pop_item.value;
      end
      MODE_REARM: begin
        wr_pos_nxt   = '0;
        pre_cnt_nxt  = '0;
        post_cnt_nxt = '0;
        fired_nxt    = 1'b0;
        done_nxt     = 1'b0;
        trig_nxt     = '0;
        base_nxt     = '0;
        fill_nxt     = '0;
      end
      MODE_READ: begin
        ram_re  = issue;
        // unwritten entries read as zero
        hit_nxt = done_r &&
                  ((32'(fill_r) == 32'(DEPTH)) || (32'(rd_idx) < 32'(fill_r)));
      end
      default: ;
    endcase
  end

  assign trig_ext = (AW+OFF_W)'(trig_nxt);

  // capture state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r   <= '0;
      pre_cnt_r  <= '0;
      post_cnt_r <= '0;
      fired_r    <= 1'b0;
      done_r     <= 1'b0;
      trig_r     <= '0;
      base_r     <= '0;
      prev_r     <= '0;
      fill_r     <= '0;
    end else if (issue) begin
      wr_pos_r   <= wr_pos_nxt;
      pre_cnt_r  <= pre_cnt_nxt;
      post_cnt_r <= post_cnt_nxt;
      fired_r    <= fired_nxt;
      done_r     <= done_nxt;
      trig_r     <= trig_nxt;
      base_r     <= base_nxt;
      prev_r     <= prev_nxt;
      fill_r     <= fill_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (issue) begin
      out_sample_value_r <= (pop_item.mode == MODE_SAMPLE) ? pop_item.value : '0;
      out_hit_r          <= hit_nxt;
      out_fired_r        <= fired_nxt;
      out_done_r         <= done_nxt;
      out_trig_pos_r     <= trig_ext[OFF_W-1:0];
    end
  end

  // sample ring
  etwc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos_r),
    .wdata (pop_item.value),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  assign out_valid            = out_valid_r;
  assign out_sample_value     = out_sample_value_r;
  assign out_read_sample      = out_hit_r ? ram_rdata : '0;
  assign out_is_triggered     = out_fired_r;
  assign out_capture_done     = out_done_r;
  assign out_trigger_position = out_trig_pos_r;

endmodule

FILE: sv/edge_triggered_window_capture.sv
// The input beat passes the front stage register, a queue slot and the result
// register before the result is valid; result stalls delay it further.
// Throughput: one item per cycle while the result is not stalled; each item uses
// the ring's single write and single read port at most once.
// Reset: synchronous active-low; flags, counters, config and queue clear, and a
// fill count marks unwritten ring entries, which read as zero.
// ---------------------------------------------------------------------------
// edge_triggered_window_capture
// Edge-triggered capture of a pre/post-trigger sample window in a ring.
// ---------------------------------------------------------------------------
module edge_triggered_window_capture
  import etwc_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [RAW_W-1:0]      in_raw_word,
  input  logic [OFF_W-1:0]      in_read_offset,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_sample_value,
  output logic [SAMPLE_W-1:0]   out_read_sample,
  output logic                  out_is_triggered,
  output logic                  out_capture_done,
  output logic [OFF_W-1:0]      out_trigger_position
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // classify and convert
  etwc_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_raw_word    (in_raw_word),
    .in_read_offset (in_read_offset),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // decoupling queue
  etwc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // capture engine
  etwc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .pop_valid            (pop_valid),
    .pop_ready            (pop_ready),
    .pop_item             (pop_item),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_sample_value     (out_sample_value),
    .out_read_sample      (out_read_sample),
    .out_is_triggered     (out_is_triggered),
    .out_capture_done     (out_capture_done),
    .out_trigger_position (out_trigger_position)
  );

endmodule

FILE: sv/etwc_checker.sv
// ---------------------------------------------------------------------------
// etwc_checker
// Port-level checks for the window capture block, bound to the top level.
// ---------------------------------------------------------------------------
module etwc_checker
  import etwc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [SAMPLE_W-1:0]   out_sample_value,
  input logic [SAMPLE_W-1:0]   out_read_sample,
  input logic                  out_is_triggered,
  input logic                  out_capture_done,
  input logic [OFF_W-1:0]      out_trigger_position
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_value) &&
      $stable(out_read_sample) && $stable(out_is_triggered) &&
      $stable(out_capture_done) && $stable(out_trigger_position))
    else $error("result beat changed while stalled");

  // a finished capture has always triggered
  a_done_needs_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_capture_done || out_is_triggered))
    else $error("capture done without trigger");

  // window data only comes out of a frozen capture
  a_read_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_sample != '0) |-> out_capture_done)
    else $error("window sample before capture done");

  // a beat is never both a sample and a read
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_value == '0) || (out_read_sample == '0))
    else $error("sample and window data in one beat");

endmodule

bind edge_triggered_window_capture etwc_checker u_etwc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_sample_value     (out_sample_value),
  .out_read_sample      (out_read_sample),
  .out_is_triggered     (out_is_triggered),
  .out_capture_done     (out_capture_done),
  .out_trigger_position (out_trigger_position)
);
